>>> hw/rtl/flrc_pkg.sv
package flrc_pkg;

  // Result codes carried on the response channel.
  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2
  } flrc_status_e;

  // Item kinds carried on the request channel.
  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } flrc_kind_e;

  // Write command from the control path to the slot store.
  typedef struct packed {
    logic flush;  // generation changed: drop every valid bit first
    logic we;     // write the value into the addressed slot
    logic alloc;  // also write the key and set the slot valid
  } flrc_slot_cmd_t;

endpackage

>>> hw/rtl/flrc_intf.sv
interface flrc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] value_in_high;
  logic [63:0] value_in_low;
  logic [31:0] table_generation;

  modport source (
    output valid, kind, key_high, key_low, value_in_high, value_in_low,
           table_generation,
    input  ready
  );

  modport sink (
    input  valid, kind, key_high, key_low, value_in_high, value_in_low,
           table_generation,
    output ready
  );
endinterface

interface flrc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value_high;
  logic [63:0] value_low;

  modport source (
    output valid, status, value_high, value_low,
    input  ready
  );

  modport sink (
    input  valid, status, value_high, value_low,
    output ready
  );
endinterface

>>> hw/rtl/fifo_replacement_lookup_cache_top.sv
// A transferred request is first held in the request register and then served into the
// response register, from which its response transfers to the receiver.
// Throughput: one request per cycle while the receiver keeps ready high; all slot compares
// happen in parallel in a single pass. A stalled response holds the request register, and
// the input stalls once both registers are full.
// Reset (rst_ni, asynchronous, active low) clears all slot valid bits, the stored generation
// and the replacement pointer; slot keys and values are not reset and are only read when valid.
module fifo_replacement_lookup_cache_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flrc_req_if.sink    req_i,
  flrc_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);

  // Request register. It holds one transferred request until its single pass is done.
  logic        req_valid_q;
  logic        kind_q;
  logic [63:0] key_high_q;
  logic [63:0] key_low_q;
  logic [63:0] value_in_high_q;
  logic [63:0] value_in_low_q;
  logic [31:0] generation_q;

  // Cache control state.
  logic [31:0]     seen_gen_q, seen_gen_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  // Response register.
  logic                   rsp_valid_q, rsp_valid_d;
  flrc_pkg::flrc_status_e status_q, status_d;
  logic [63:0]            value_high_q, value_high_d;
  logic [63:0]            value_low_q, value_low_d;

  logic                     advance;
  logic                     gen_change;
  logic                     is_insert;
  logic                     hit;
  logic [IdxW-1:0]          hit_idx;
  logic [63:0]              hit_value_high;
  logic [63:0]              hit_value_low;
  logic [IdxW-1:0]          base_ptr;
  logic [IdxW-1:0]          wr_idx;
  flrc_pkg::flrc_slot_cmd_t cmd;

  // The held request is served when the response register is free or being drained.
  // A new request is taken whenever the request register is empty or being served,
  // so a response waiting on the receiver stalls the input only while a request is held.
  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;

  assign gen_change = (generation_q != seen_gen_q);
  assign is_insert  = (kind_q == flrc_pkg::KIND_INSERT);

  // After a generation change the pointer restarts at slot zero before the insert uses it.
  assign base_ptr = gen_change ? '0 : ptr_q;

  always_comb begin
    cmd.flush = advance && gen_change;
    cmd.we    = advance && is_insert;
    cmd.alloc = advance && is_insert && !hit;
  end

  // A repeated key keeps its slot and only takes the new value.
  assign wr_idx = hit ? hit_idx : base_ptr;

  flrc_slots #(
    .SLOTS (SLOTS),
    .IDX_W (IdxW)
  ) u_slots (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_high_i       (key_high_q),
    .key_low_i        (key_low_q),
    .value_high_i     (value_in_high_q),
    .value_low_i      (value_in_low_q),
    .cmd_i            (cmd),
    .lookup_flush_i   (gen_change),
    .wr_idx_i         (wr_idx),
    .hit_o            (hit),
    .hit_idx_o        (hit_idx),
    .hit_value_high_o (hit_value_high),
    .hit_value_low_o  (hit_value_low)
  );

  // Generation tracking and the round-robin replacement pointer, which wraps after the
  // last slot also when the slot count is not a power of two.
  always_comb begin
    seen_gen_d = seen_gen_q;
    ptr_d      = ptr_q;
    if (advance) begin
      seen_gen_d = generation_q;
      ptr_d      = base_ptr;
      if (cmd.alloc) begin
        ptr_d = (base_ptr == IdxW'(SLOTS - 1)) ? '0 : base_ptr + IdxW'(1);
      end
    end
  end

  // Response formation.
  always_comb begin
    rsp_valid_d  = rsp_valid_q;
    status_d     = status_q;
    value_high_d = value_high_q;
    value_low_d  = value_low_q;
    if (advance) begin
      rsp_valid_d = 1'b1;
      if (is_insert) begin
        status_d     = flrc_pkg::ST_INSERTED;
        value_high_d = value_in_high_q;
        value_low_d  = value_in_low_q;
      end else if (hit) begin
        status_d     = flrc_pkg::ST_HIT;
        value_high_d = hit_value_high;
        value_low_d  = hit_value_low;
      end else begin
        status_d     = flrc_pkg::ST_MISS;
        value_high_d = '0;
        value_low_d  = '0;
      end
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      seen_gen_q  <= '0;
      ptr_q       <= '0;
    end else begin
      req_valid_q <= req_i.valid || (req_valid_q && !advance);
      rsp_valid_q <= rsp_valid_d;
      seen_gen_q  <= seen_gen_d;
      ptr_q       <= ptr_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q          <= req_i.kind;
      key_high_q      <= req_i.key_high;
      key_low_q       <= req_i.key_low;
      value_in_high_q <= req_i.value_in_high;
      value_in_low_q  <= req_i.value_in_low;
      generation_q    <= req_i.table_generation;
    end
    status_q     <= status_d;
    value_high_q <= value_high_d;
    value_low_q  <= value_low_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.value_high = value_high_q;
  assign rsp_o.value_low  = value_low_q;

  // The replacement pointer always names an existing slot.
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= IdxW'(SLOTS - 1))
    else $error("replacement pointer out of range");

  // A served insert always answers with the inserted status.
  a_insert_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_insert |=> status_q == flrc_pkg::ST_INSERTED)
    else $error("insert did not report inserted");

  // A miss never carries a value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && status_q == flrc_pkg::ST_MISS |-> value_high_q == '0 && value_low_q == '0)
    else $error("miss response carries a value");

  // After any served request the stored generation is the request's generation.
  a_gen_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> seen_gen_q == $past(generation_q))
    else $error("generation not tracked");

endmodule

>>> hw/rtl/flrc_slots.sv
module flrc_slots #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [63:0]             key_high_i,
  input  logic [63:0]             key_low_i,
  input  logic [63:0]             value_high_i,
  input  logic [63:0]             value_low_i,
  input  flrc_pkg::flrc_slot_cmd_t cmd_i,
  input  logic                    lookup_flush_i,
  input  logic [IDX_W-1:0]        wr_idx_i,
  output logic                    hit_o,
  output logic [IDX_W-1:0]        hit_idx_o,
  output logic [63:0]             hit_value_high_o,
  output logic [63:0]             hit_value_low_o
);

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [63:0]      key_high_q   [SLOTS];
  logic [63:0]      key_low_q    [SLOTS];
  logic [63:0]      value_high_q [SLOTS];
  logic [63:0]      value_low_q  [SLOTS];
  logic [SLOTS-1:0] match;

  // Every slot compares in parallel. A pending flush hides all slots.
  always_comb begin
    for (int unsigned i = 0; i < SLOTS; i++) begin
      match[i] = valid_q[i] && !lookup_flush_i &&
                 (key_high_q[i] == key_high_i) && (key_low_q[i] == key_low_i);
    end
  end

  // Lowest matching index wins.
  always_comb begin
    hit_idx_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = IDX_W'(i);
      end
    end
  end

  assign hit_o            = |match;
  assign hit_value_high_o = value_high_q[hit_idx_o];
  assign hit_value_low_o  = value_low_q[hit_idx_o];

  always_comb begin
    valid_d = cmd_i.flush ? '0 : valid_q;
    if (cmd_i.alloc) begin
      valid_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      value_high_q[wr_idx_i] <= value_high_i;
      value_low_q[wr_idx_i]  <= value_low_i;
    end
    if (cmd_i.alloc) begin
      key_high_q[wr_idx_i] <= key_high_i;
      key_low_q[wr_idx_i]  <= key_low_i;
    end
  end

  // An allocation always leaves its slot valid.
  a_alloc_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |=> valid_q[$past(wr_idx_i)])
    else $error("allocated slot is not valid");

  // A flush without allocation leaves no slot valid.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush && !cmd_i.alloc |=> valid_q == '0)
    else $error("flush left a valid slot");

  // The key store never holds two valid copies of the looked-up key.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key matches more than one slot");

endmodule

>>> verif/flrc_cache_checker.sv
module flrc_cache_checker #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flrc_req_if         req_i,
  flrc_rsp_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned owed_o,
  output int unsigned hits_o,
  output int unsigned misses_o,
  output int unsigned inserts_o,
  output int unsigned evictions_o,
  output int unsigned flushes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    flrc_pkg::flrc_status_e status;
    logic [63:0]            value_high;
    logic [63:0]            value_low;
  } cache_answer_t;

  // Shadow copy of the slot store.
  logic        live_q      [SLOTS];
  logic [63:0] tag_high_q  [SLOTS];
  logic [63:0] tag_low_q   [SLOTS];
  logic [63:0] val_high_q  [SLOTS];
  logic [63:0] val_low_q   [SLOTS];
  logic [31:0] gen_q;
  int unsigned fill_ptr_q;

  cache_answer_t owed_answers[$];
  cache_answer_t want;
  int unsigned   answer_idx;

  // Applies one request to the shadow store and returns the answer it must produce.
  function automatic cache_answer_t model_access(flrc_pkg::flrc_kind_e kind, logic [63:0] kh,
                                                 logic [63:0] kl, logic [63:0] vh,
                                                 logic [63:0] vl, logic [31:0] gen);
    cache_answer_t ans;
    int            match;
    int            slot;
    if (gen != gen_q) begin
      for (int i = 0; i < SLOTS; i++) live_q[i] = 1'b0;
      gen_q      = gen;
      fill_ptr_q = 0;
      flushes_o++;
    end
    match = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (match < 0 && live_q[i] && tag_high_q[i] == kh && tag_low_q[i] == kl) match = i;
    end
    if (kind == flrc_pkg::KIND_LOOKUP) begin
      if (match >= 0) begin
        ans = '{flrc_pkg::ST_HIT, val_high_q[match], val_low_q[match]};
        hits_o++;
      end else begin
        ans = '{flrc_pkg::ST_MISS, 64'd0, 64'd0};
        misses_o++;
      end
    end else begin
      slot = match;
      if (slot < 0) begin
        // A new key goes to the slot under the round-robin pointer.
        slot       = fill_ptr_q;
        fill_ptr_q = (fill_ptr_q + 1 >= SLOTS) ? 0 : fill_ptr_q + 1;
        if (live_q[slot]) evictions_o++;
        tag_high_q[slot] = kh;
        tag_low_q[slot]  = kl;
        live_q[slot]     = 1'b1;
      end
      val_high_q[slot] = vh;
      val_low_q[slot]  = vl;
      ans = '{flrc_pkg::ST_INSERTED, vh, vl};
      inserts_o++;
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) live_q[i] = 1'b0;
      gen_q       = '0;
      fill_ptr_q  = 0;
      owed_answers.delete();
      answer_idx  = 0;
      errors_o    = 0;
      owed_o      = 0;
      hits_o      = 0;
      misses_o    = 0;
      inserts_o   = 0;
      evictions_o = 0;
      flushes_o   = 0;
    end else begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        owed_answers.push_back(model_access(flrc_pkg::flrc_kind_e'(req_i.kind),
                                            req_i.key_high, req_i.key_low,
                                            req_i.value_in_high, req_i.value_in_low,
                                            req_i.table_generation));
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (owed_answers.size() == 0) begin
          errors_o++;
          if (errors_o <= REPORT_LIMIT) begin
            $display("[%0t] response %0d arrived with no request outstanding", $realtime,
                     answer_idx);
          end
        end else begin
          want = owed_answers.pop_front();
          if (rsp_i.status !== want.status || rsp_i.value_high !== want.value_high ||
              rsp_i.value_low !== want.value_low) begin
            errors_o++;
            if (errors_o <= REPORT_LIMIT) begin
              $display("[%0t] response %0d: expected status %0d value %h_%h, got %0d %h_%h",
                       $realtime, answer_idx, want.status, want.value_high, want.value_low,
                       rsp_i.status, rsp_i.value_high, rsp_i.value_low);
            end
          end
        end
        answer_idx++;
      end
      owed_o = owed_answers.size();
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned RANDOM_ITEMS = 1200;
  // Pool of reusable keys. It is larger than the cache so that hits, misses and
  // round-robin evictions all show up in the random traffic.
  localparam int unsigned POOL         = 12;
  // The worst case per transfer (sender gap plus a slow receiver) stays far
  // below this limit, so it leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  flrc_req_if req_if ();
  flrc_rsp_if rsp_if ();

  int unsigned errors;
  int unsigned owed;
  int unsigned hits;
  int unsigned misses;
  int unsigned inserts;
  int unsigned evictions;
  int unsigned flushes;

  fifo_replacement_lookup_cache_top #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // The checker watches both channels, keeps its own copy of the cache and
  // compares every response transfer against its prediction.
  flrc_cache_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .errors_o   (errors),
    .owed_o     (owed),
    .hits_o     (hits),
    .misses_o   (misses),
    .inserts_o  (inserts),
    .evictions_o(evictions),
    .flushes_o  (flushes)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fifo_replacement_lookup_cache_top verification failed");
      $finish;
    end
  end

  // Response side back-pressure. The receiver switches between four stall
  // behaviors, each held for a random span: always ready, coin flip, mostly stalled,
  // and a fixed periodic pattern, so stalls land on every phase of the output.
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned phase      = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 300);
      end
      mode_left--;
      phase++;
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= ((phase % 5) < 2);
      endcase
    end
  end

  // Request side state: the generation that goes out with every item, the
  // burst bookkeeping, and the key pool.
  logic [31:0] table_gen   = '0;
  int unsigned burst_left  = 0;
  int unsigned items_sent  = 0;
  logic [63:0] pool_high [POOL];
  logic [63:0] pool_low  [POOL];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Drives one request and returns at the edge where it transfers. Valid stays
  // high into the next item unless a gap between bursts follows, so the sender
  // sends in bursts of random length with random gaps.
  task automatic push_request(flrc_pkg::flrc_kind_e kind, logic [63:0] kh, logic [63:0] kl,
                              logic [63:0] vh, logic [63:0] vl);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid            <= 1'b1;
    req_if.kind             <= kind;
    req_if.key_high         <= kh;
    req_if.key_low          <= kl;
    req_if.value_in_high    <= vh;
    req_if.value_in_low     <= vl;
    req_if.table_generation <= table_gen;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    items_sent++;
  endtask

  initial begin
    int unsigned directed_count;
    int unsigned random_target;
    int unsigned p;
    int unsigned sel;
    logic [63:0] vh;
    logic [63:0] vl;

    rst_ni                  <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.kind             <= flrc_pkg::KIND_LOOKUP;
    req_if.key_high         <= '0;
    req_if.key_low          <= '0;
    req_if.value_in_high    <= '0;
    req_if.value_in_low     <= '0;
    req_if.table_generation <= '0;
    for (int i = 0; i < POOL; i++) begin
      pool_high[i] = rand64();
      pool_low[i]  = rand64();
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The generation stays at its reset value first, so nothing
    // is flushed until the explicit generation changes below.
    push_request(flrc_pkg::KIND_LOOKUP, '0, '0, '1, '1);  // empty cache: miss
    push_request(flrc_pkg::KIND_INSERT, '0, '0, '1, '1);  // zero key, all-ones value
    push_request(flrc_pkg::KIND_LOOKUP, '0, '0, '0, '0);  // zero key hits
    push_request(flrc_pkg::KIND_INSERT, '1, '1, '0, '0);  // all-ones key, zero value
    push_request(flrc_pkg::KIND_LOOKUP, '1, '1, '1, '1);  // hit returns zero value
    // Re-inserting a cached key updates the value in place; the pointer stays.
    push_request(flrc_pkg::KIND_INSERT, '0, '0, rand64(), rand64());
    push_request(flrc_pkg::KIND_LOOKUP, '0, '0, rand64(), rand64());
    // Eight new keys walk the pointer around the ring and evict both keys above.
    for (int i = 0; i < 8; i++) begin
      push_request(flrc_pkg::KIND_INSERT, pool_high[i], pool_low[i], rand64(), rand64());
    end
    push_request(flrc_pkg::KIND_LOOKUP, '0, '0, rand64(), rand64());  // evicted: miss
    // Keys that match in one half only must miss.
    push_request(flrc_pkg::KIND_LOOKUP, pool_high[3], ~pool_low[3], rand64(), rand64());
    push_request(flrc_pkg::KIND_LOOKUP, ~pool_high[3], pool_low[3], rand64(), rand64());
    push_request(flrc_pkg::KIND_LOOKUP, pool_high[5], pool_low[5], rand64(), rand64());
    // A generation change on an insert flushes first, then writes slot 0.
    table_gen = '1;
    push_request(flrc_pkg::KIND_INSERT, pool_high[9], pool_low[9], rand64(), rand64());
    push_request(flrc_pkg::KIND_LOOKUP, pool_high[5], pool_low[5], rand64(), rand64());
    push_request(flrc_pkg::KIND_LOOKUP, pool_high[9], pool_low[9], rand64(), rand64());
    // A generation change on a lookup flushes as well.
    table_gen = '0;
    push_request(flrc_pkg::KIND_LOOKUP, pool_high[9], pool_low[9], rand64(), rand64());
    directed_count = items_sent;

    // Random part. Most traffic reuses pool keys, including the well-formed
    // lookup, insert after the miss, lookup again sequence; the rest is fresh
    // keys, near-miss keys, pool churn and occasional generation changes.
    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      if ($urandom_range(0, 99) < 2) begin
        case ($urandom_range(0, 3))
          0:       table_gen = $urandom;
          1:       table_gen = table_gen + 1;
          2:       table_gen = '0;
          default: table_gen = '1;
        endcase
      end
      if ($urandom_range(0, 99) < 3) begin
        p = $urandom_range(0, POOL - 1);
        pool_high[p] = rand64();
        pool_low[p]  = rand64();
      end
      p   = $urandom_range(0, POOL - 1);
      sel = $urandom_range(0, 99);
      vh  = rand64();
      vl  = rand64();
      if (sel < 40) begin
        push_request(flrc_pkg::KIND_LOOKUP, pool_high[p], pool_low[p], vh, vl);
      end else if (sel < 70) begin
        push_request(flrc_pkg::KIND_INSERT, pool_high[p], pool_low[p], vh, vl);
      end else if (sel < 80) begin
        push_request(flrc_pkg::KIND_LOOKUP, pool_high[p], pool_low[p], rand64(), rand64());
        push_request(flrc_pkg::KIND_INSERT, pool_high[p], pool_low[p], vh, vl);
        push_request(flrc_pkg::KIND_LOOKUP, pool_high[p], pool_low[p], rand64(), rand64());
      end else if (sel < 88) begin
        push_request(flrc_pkg::KIND_LOOKUP, rand64(), rand64(), vh, vl);
      end else if (sel < 93) begin
        push_request(flrc_pkg::KIND_INSERT, rand64(), rand64(), vh, vl);
      end else if (sel < 97) begin
        if ($urandom_range(0, 1) == 0) begin
          push_request(flrc_pkg::KIND_LOOKUP, pool_high[p], rand64(), vh, vl);
        end else begin
          push_request(flrc_pkg::KIND_LOOKUP, rand64(), pool_low[p], vh, vl);
        end
      end else begin
        push_request(flrc_pkg::flrc_kind_e'($urandom_range(0, 1)),
                     ($urandom_range(0, 1) == 0) ? '0 : '1,
                     ($urandom_range(0, 1) == 0) ? '0 : '1, vh, vl);
      end
    end

    // Drain: stop sending, wait for every predicted response to transfer, then
    // wait out DRAIN_CYCLES more so a stray extra response would still be caught.
    req_if.valid <= 1'b0;
    while (owed != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d request transfers (%0d directed): %0d hits, %0d misses, %0d inserts.",
             items_sent, directed_count, hits, misses, inserts);
    $display("%0d inserts evicted a live slot and %0d generation changes flushed the cache.",
             evictions, flushes);
    if (errors == 0 && owed == 0) begin
      $display("fifo_replacement_lookup_cache_top verification clean");
    end else begin
      $display("fifo_replacement_lookup_cache_top verification failed");
    end
    $finish;
  end

endmodule
